// File: src/srmq_pkg.sv
// ----------------------------------------------------------------------------
// srmq_pkg: shared definitions for the sparse table range minimum unit
// Sizes, command codes and the item and status records passed between parts.
// ----------------------------------------------------------------------------
`default_nettype none

package srmq_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int VALUE_BITS   = 32;
    localparam int INDEX_BITS   = $clog2(MAX_ELEMENTS);
    localparam int COUNT_BITS   = INDEX_BITS + 1;
    localparam int SPAN_BITS    = COUNT_BITS + 1;
    localparam int LEVELS       = INDEX_BITS + 1;
    localparam int LEVEL_BITS   = $clog2(LEVELS);
    localparam int ADDR_BITS    = LEVEL_BITS + INDEX_BITS;
    localparam int TABLE_DEPTH  = LEVELS * MAX_ELEMENTS;

    // Command codes.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // One classified item as it waits in the queue.
    typedef struct packed {
        logic                         is_query;
        logic signed [VALUE_BITS-1:0] value;
        logic                         last;
        logic [INDEX_BITS-1:0]        left;
        logic [INDEX_BITS-1:0]        right;
    } item_t;

    // Status of the back part.
    typedef struct packed {
        logic busy;
        logic building;
    } back_status_t;

endpackage

`default_nettype wire

// File: src/srmq_front.sv
// ----------------------------------------------------------------------------
// srmq_front: input acceptance and item queue
// Classifies each input transfer and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module srmq_front (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  command,
    input  wire logic signed [srmq_pkg::VALUE_BITS-1:0] element_value,
    input  wire logic                                  last_element,
    input  wire logic [srmq_pkg::INDEX_BITS-1:0]       left_index,
    input  wire logic [srmq_pkg::INDEX_BITS-1:0]       right_index,
    output logic                                       head_valid,
    output srmq_pkg::item_t                            head_item,
    input  wire logic                                  head_pop
);

    srmq_pkg::item_t slot_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      fill_reg, fill_next;
    logic            push;
    srmq_pkg::item_t new_item;

    // Classify the incoming transfer.
    always_comb
    begin
        new_item.is_query = (command == srmq_pkg::CMD_QUERY);
        new_item.value    = element_value;
        new_item.last     = last_element;
        new_item.left     = left_index;
        new_item.right    = right_index;
    end

    assign in_ready   = (fill_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign head_valid = (fill_reg != 2'd0);
    assign head_item  = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = head_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, head_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue payload storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

`default_nettype wire

// File: src/srmq_back.sv
// ----------------------------------------------------------------------------
// srmq_back: table store, build sequencer and query engine
// Executes queued loads and queries and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module srmq_back (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   head_valid,
    input  wire srmq_pkg::item_t                        head_item,
    output logic                                        head_pop,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [srmq_pkg::VALUE_BITS-1:0]      minimum_value,
    output logic                                        range_error,
    output srmq_pkg::back_status_t                      status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BRD  = 2'd1;
    localparam logic [1:0] ST_BWR  = 2'd2;
    localparam logic [1:0] ST_QRD  = 2'd3;

    localparam int IB = srmq_pkg::INDEX_BITS;
    localparam int CB = srmq_pkg::COUNT_BITS;
    localparam int SB = srmq_pkg::SPAN_BITS;
    localparam int LB = srmq_pkg::LEVEL_BITS;
    localparam int AB = srmq_pkg::ADDR_BITS;
    localparam int VB = srmq_pkg::VALUE_BITS;

    logic signed [VB-1:0] table_mem [srmq_pkg::TABLE_DEPTH];

    logic [1:0]    state_reg, state_next;
    logic [CB-1:0] count_reg, count_next;
    logic          ready_reg, ready_next;
    logic [LB-1:0] lvl_reg, lvl_next;
    logic [IB-1:0] pos_reg, pos_next;
    logic          out_valid_reg, out_valid_next;
    logic signed [VB-1:0] min_reg, min_next;
    logic          err_reg, err_next;

    logic                 we;
    logic [AB-1:0]        waddr, raddr0, raddr1;
    logic signed [VB-1:0] wdata, rdata0, rdata1, pair_min;

    logic [CB-1:0] eff_count, new_count, len;
    logic [LB-1:0] k;
    logic [CB-1:0] right_start;
    logic [SB-1:0] span, next_span, half, pos_end;
    logic          bad;
    logic          out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign pair_min = (rdata0 <= rdata1) ? rdata0 : rdata1;

    // Query decode: length, floor log2 and window starts.
    always_comb
    begin
        len = {1'b0, head_item.right} - {1'b0, head_item.left} + CB'(1);
        k   = '0;
        for (int b = 0; b < CB; b++)
        begin
            if (len[b])
            begin
                k = LB'(b);
            end
        end
        right_start = {1'b0, head_item.right} + CB'(1) - (CB'(1) << k);
        bad = !ready_reg || (head_item.left > head_item.right)
              || ({1'b0, head_item.right} >= count_reg);
    end

    // Build geometry for the current level.
    always_comb
    begin
        span      = SB'(1) << lvl_reg;
        half      = SB'(1) << (lvl_reg - LB'(1));
        next_span = SB'(1) << (lvl_reg + LB'(1));
        pos_end   = {{(SB-IB){1'b0}}, pos_reg} + SB'(1) + span;
    end

    // Control sequencer.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ready_next     = ready_reg;
        lvl_next       = lvl_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !out_ready;
        min_next       = min_reg;
        err_next       = err_reg;
        head_pop       = 1'b0;
        we             = 1'b0;
        waddr          = '0;
        wdata          = head_item.value;
        raddr0         = {k, head_item.left};
        raddr1         = {k, right_start[IB-1:0]};
        eff_count      = ready_reg ? '0 : count_reg;
        new_count      = eff_count;

        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid && (!head_item.is_query || out_free))
                begin
                    head_pop = 1'b1;
                    if (!head_item.is_query)
                    begin
                        // Load: restart after a build, drop values when full.
                        ready_next = 1'b0;
                        if (eff_count < CB'(srmq_pkg::MAX_ELEMENTS))
                        begin
                            we        = 1'b1;
                            waddr     = {LB'(0), eff_count[IB-1:0]};
                            new_count = eff_count + CB'(1);
                        end
                        count_next = new_count;
                        if (head_item.last)
                        begin
                            if (new_count >= CB'(2))
                            begin
                                lvl_next   = LB'(1);
                                pos_next   = '0;
                                state_next = ST_BRD;
                            end
                            else
                            begin
                                ready_next = 1'b1;
                            end
                        end
                    end
                    else if (bad)
                    begin
                        out_valid_next = 1'b1;
                        min_next       = '0;
                        err_next       = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_QRD;
                    end
                end
            end
            ST_BRD:
            begin
                raddr0     = {lvl_reg - LB'(1), pos_reg};
                raddr1     = {lvl_reg - LB'(1),
                              pos_reg + half[IB-1:0]};
                state_next = ST_BWR;
            end
            ST_BWR:
            begin
                we    = 1'b1;
                waddr = {lvl_reg, pos_reg};
                wdata = pair_min;
                if (pos_end <= {1'b0, count_reg})
                begin
                    pos_next   = pos_reg + IB'(1);
                    state_next = ST_BRD;
                end
                else if ((32'(lvl_reg) + 1 < srmq_pkg::LEVELS)
                         && (next_span <= {1'b0, count_reg}))
                begin
                    lvl_next   = lvl_reg + LB'(1);
                    pos_next   = '0;
                    state_next = ST_BRD;
                end
                else
                begin
                    ready_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_QRD:
            begin
                out_valid_next = 1'b1;
                min_next       = pair_min;
                err_next       = 1'b0;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ready_reg     <= 1'b0;
            lvl_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ready_reg     <= ready_next;
            lvl_reg       <= lvl_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        min_reg <= min_next;
        err_reg <= err_next;
    end

    // Table store: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            table_mem[waddr] <= wdata;
        end
        rdata0 <= table_mem[raddr0];
        rdata1 <= table_mem[raddr1];
    end

    assign out_valid       = out_valid_reg;
    assign minimum_value   = min_reg;
    assign range_error     = err_reg;
    assign status.busy     = (state_reg != ST_IDLE);
    assign status.building = (state_reg == ST_BRD) || (state_reg == ST_BWR);

endmodule

`default_nettype wire

// File: src/sparse_table_range_min_unit.sv
// ----------------------------------------------------------------------------
// sparse_table_range_min_unit: range minimum over a loaded sequence
// Loads signed elements, builds a sparse table and answers range queries.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  input   | in_valid / in_ready  | command, element_value, last_element,
//          |                      | left_index, right_index
//  output  | out_valid / out_ready| minimum_value, range_error
//
// A load is written by the back part as it is taken; a query passes through a
// table read and then the result register. The last load starts a build in which
// the sequencer takes a read step and then a write step for each table entry.
// Reset clears the counters and flags; table contents are undefined until built.
// A two-entry queue keeps accepting input while a result waits for out_ready.
`default_nettype none

module sparse_table_range_min_unit (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic                                   command,
    input  wire logic signed [srmq_pkg::VALUE_BITS-1:0] element_value,
    input  wire logic                                   last_element,
    input  wire logic [srmq_pkg::INDEX_BITS-1:0]        left_index,
    input  wire logic [srmq_pkg::INDEX_BITS-1:0]        right_index,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [srmq_pkg::VALUE_BITS-1:0]      minimum_value,
    output logic                                        range_error
);

    logic                   head_valid;
    srmq_pkg::item_t        head_item;
    logic                   head_pop;
    srmq_pkg::back_status_t status;

    srmq_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .element_value (element_value),
        .last_element  (last_element),
        .left_index    (left_index),
        .right_index   (right_index),
        .head_valid    (head_valid),
        .head_item     (head_item),
        .head_pop      (head_pop)
    );

    srmq_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_item     (head_item),
        .head_pop      (head_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .minimum_value (minimum_value),
        .range_error   (range_error),
        .status        (status)
    );

    // A rejected query always reports a zero minimum.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> minimum_value == '0)
        else $error("range error with nonzero minimum");

    // No queue item is taken while the table is being built.
    a_no_pop_build: assert property (@(posedge clk) disable iff (!rst_n)
        status.building |-> !head_pop)
        else $error("queue popped during build");

    // Items are only taken from a non-empty queue while the back part is idle.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> head_valid && !status.busy)
        else $error("pop from empty queue or busy back part");

endmodule

`default_nettype wire

// File: dv/sparse_table_range_min_unit_tb.sv
// ----------------------------------------------------------------------------
// sparse_table_range_min_unit_tb: self-checking bench for the range minimum unit
// Loads random sequences, queries random ranges and compares every answer with
// a direct scan over the loaded elements, under random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// Holds the loaded sequence and the answers still owed by the block.
class range_min_scoreboard;
    logic signed [srmq_pkg::VALUE_BITS-1:0] elements[srmq_pkg::MAX_ELEMENTS];
    int                                     count;
    bit                                     built;
    logic signed [srmq_pkg::VALUE_BITS-1:0] min_queue[$];
    bit                                     err_queue[$];
    int                                     failures;

    function new();
        count    = 0;
        built    = 0;
        failures = 0;
    endfunction

    // Update the sequence or predict a query answer for one accepted transfer.
    function void note_input(logic cmd, logic signed [srmq_pkg::VALUE_BITS-1:0] val,
                             logic last, logic [srmq_pkg::INDEX_BITS-1:0] left,
                             logic [srmq_pkg::INDEX_BITS-1:0] right);
        logic signed [srmq_pkg::VALUE_BITS-1:0] m;
        if (cmd == srmq_pkg::CMD_LOAD) begin
            if (built) begin
                count = 0;
                built = 0;
            end
            if (count < srmq_pkg::MAX_ELEMENTS) begin
                elements[count] = val;
                count++;
            end
            if (last)
                built = 1;
        end
        else if (!built || left > right || right >= count) begin
            min_queue = {min_queue, '0};
            err_queue = {err_queue, 1'b1};
        end
        else begin
            m = elements[left];
            for (int i = left + 1; i <= right; i++)
                if (elements[i] < m)
                    m = elements[i];
            min_queue = {min_queue, m};
            err_queue = {err_queue, 1'b0};
        end
    endfunction

    // Compare one result transfer with the oldest prediction.
    function void check_result(logic signed [srmq_pkg::VALUE_BITS-1:0] mv, logic re);
        logic signed [srmq_pkg::VALUE_BITS-1:0] em;
        bit                                     ee;
        if (min_queue.size() == 0) begin
            $error("unexpected result: minimum_value %0d range_error %0b", mv, re);
            failures++;
            return;
        end
        em = min_queue.pop_front();
        ee = err_queue.pop_front();
        if (mv !== em) begin
            $error("minimum_value: expected %0d actual %0d", em, mv);
            failures++;
        end
        if (re !== ee) begin
            $error("range_error: expected %0b actual %0b", ee, re);
            failures++;
        end
    endfunction

    function int pending();
        return min_queue.size();
    endfunction
endclass

module sparse_table_range_min_unit_tb;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int IB = srmq_pkg::INDEX_BITS;
    localparam int VB = srmq_pkg::VALUE_BITS;

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  in_valid = 0;
    logic                  in_ready;
    logic                  command = srmq_pkg::CMD_LOAD;
    logic signed [VB-1:0]  element_value = '0;
    logic                  last_element = 0;
    logic [IB-1:0]         left_index = '0;
    logic [IB-1:0]         right_index = '0;
    logic                  out_valid;
    logic                  out_ready = 0;
    logic signed [VB-1:0]  minimum_value;
    logic                  range_error;

    range_min_scoreboard scoreboard = new();
    bit  quiet_phase = 0;
    bit  hold_off_request = 0;
    int  idle_cycles = 0;

    sparse_table_range_min_unit i_dut (.*);

    always #10 clk = ~clk;

    // Note accepted inputs, check results and watch for a hang.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                scoreboard.note_input(command, element_value, last_element,
                                      left_index, right_index);
            if (out_valid && out_ready)
                scoreboard.check_result(minimum_value, range_error);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[sparse_table_range_min_unit] ERROR");
                $finish;
            end
        end
    end

    // Receiver: random stalls, one long hold-off on request, none at the end.
    initial begin
        int stall;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_off_request) begin
                out_ready <= 0;
                for (int i = 0; i < 300; i++)
                    @(posedge clk);
                hold_off_request = 0;
                out_ready <= 1;
            end
            else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 12);
                out_ready <= 0;
                repeat (stall) @(posedge clk);
                out_ready <= 1;
            end
            else
                out_ready <= 1;
        end
    end

    // Offer one transfer and hold it until accepted, with an optional gap first.
    task automatic send_item(logic cmd, logic signed [VB-1:0] val, logic last,
                             logic [IB-1:0] left, logic [IB-1:0] right);
        int gap;
        if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1;
        command       <= cmd;
        element_value <= val;
        last_element  <= last;
        left_index    <= left;
        right_index   <= right;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic query(int left, int right);
        send_item(srmq_pkg::CMD_QUERY, $urandom, 1'($urandom_range(0, 1)),
                  IB'(left), IB'(right));
    endtask

    // Load a sequence of n elements; values come from a narrow or full range.
    // The final element carries the last mark only when mark_last is set.
    task automatic load_sequence(int n, bit narrow, bit mark_last);
        logic signed [VB-1:0] v;
        for (int i = 0; i < n; i++) begin
            v = narrow ? $signed($urandom_range(0, 20)) - 10 : $urandom;
            send_item(srmq_pkg::CMD_LOAD, v, mark_last && (i == n - 1),
                      IB'($urandom), IB'($urandom));
        end
    endtask

    // A range that is usually valid for a table of n elements.
    task automatic random_query(int n);
        int l, r;
        if ($urandom_range(0, 9) == 0) begin
            query($urandom_range(0, 1023), $urandom_range(0, 1023));
        end
        else begin
            l = $urandom_range(0, n - 1);
            r = $urandom_range(l, n - 1);
            query(l, r);
        end
    endtask

    task automatic drain();
        in_valid <= 0;
        while (scoreboard.pending() != 0)
            @(posedge clk);
    endtask

    initial begin
        int n;
        int sent;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: query before any table, then extreme values and ranges.
        query(0, 0);
        send_item(srmq_pkg::CMD_LOAD, 32'sh7fffffff, 0, 0, 0);
        query(0, 0);
        send_item(srmq_pkg::CMD_LOAD, 32'sh80000000, 0, 1023, 1023);
        send_item(srmq_pkg::CMD_LOAD, -1, 0, 0, 0);
        send_item(srmq_pkg::CMD_LOAD, 0, 1, 0, 0);
        query(0, 3);
        query(0, 0);
        query(1, 2);
        query(2, 3);
        query(3, 3);
        query(2, 1);
        query(0, 4);
        query(1023, 1023);
        // A load after a build starts a new sequence; query while loading fails.
        send_item(srmq_pkg::CMD_LOAD, 5, 0, 0, 0);
        query(0, 0);
        send_item(srmq_pkg::CMD_LOAD, 3, 1, 0, 0);
        query(0, 1);
        query(0, 2);
        drain();

        // Full table, with one load beyond capacity carrying the last mark.
        load_sequence(srmq_pkg::MAX_ELEMENTS, 0, 0);
        send_item(srmq_pkg::CMD_LOAD, 32'sh80000000, 1, 0, 0);
        query(0, 1023);
        query(1, 1023);
        query(511, 512);
        query(1023, 1023);
        drain();

        // Long receiver hold-off while queries keep coming.
        hold_off_request = 1;
        for (int i = 0; i < 12; i++)
            random_query(srmq_pkg::MAX_ELEMENTS);
        drain();

        // Random sequences, mostly small, each followed by queries.
        sent = 0;
        while (sent < 200) begin
            if (sent > 150)
                quiet_phase = 1;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 200)
                                             : $urandom_range(1, 16);
            load_sequence(n, $urandom_range(0, 1), 1);
            sent += n;
            for (int q = $urandom_range(4, 16); q > 0; q--) begin
                random_query(n);
                sent++;
            end
            if ($urandom_range(0, 3) == 0)
                drain();
        end
        drain();
        repeat (20) @(posedge clk);
        if (scoreboard.failures == 0 && scoreboard.pending() == 0)
            $display("[sparse_table_range_min_unit] OK");
        else
            $display("[sparse_table_range_min_unit] ERROR");
        $finish;
    end

endmodule
